### src/psdf_pkg.sv
// shared types and constants of the particle splat distance field block
package psdf_pkg;

	// width of signed coordinate arithmetic (cell plus window offset)
	localparam int CW = 14;
	// width of a signed window offset
	localparam int OW = 8;
	// width of a squared cell distance inside the largest window
	localparam int D2W = 14;
	// width of the configuration register index
	localparam int IDXW = 3;

	localparam logic [1:0] FUNC_ADD   = 2'd0;
	localparam logic [1:0] FUNC_QUERY = 2'd1;
	localparam logic [1:0] FUNC_CLEAR = 2'd2;

	localparam logic [IDXW-1:0] REG_GRID_SIZE   = 3'd0;
	localparam logic [IDXW-1:0] REG_SPLAT_REACH = 3'd1;
	localparam logic [IDXW-1:0] REG_SPLAT_LIMIT = 3'd2;
	localparam logic [IDXW-1:0] REG_CELL_SIZE   = 3'd3;
	localparam logic [IDXW-1:0] REG_EMPTY_VALUE = 3'd4;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SPLAT,
		ST_QCENTER,
		ST_QWAIT,
		ST_SCAN,
		ST_DRAIN,
		ST_PROD,
		ST_MUL,
		ST_SQRT,
		ST_OUT
	} state_t;

endpackage

### src/particle_splat_distance_field.sv
// top level: occupancy bitmap with particle splat, clear sweep and distance query
// The occupancy bitmap is a single-port one-bit memory of 2^(2*ceil(log2 GRID_MAX)) cells
// (65536 at the default) with a registered read. After reset and for every clear item the
// block sweeps the whole memory, one cell per cycle, and takes no input item meanwhile;
// configuration writes are always taken. An add item steps one cell per cycle over a
// (2r+1)^2 window, r the clamped splat reach, and marks the cells within the splat limit.
// A query reads the center cell, then scans the (2R+1)^2 window, R = min(grid/4, REACH_MAX),
// one cell per cycle through the memory read port, then, if a cell was found, runs a serial
// multiply and a bit-serial square root before the result is offered. The result sits in an
// output register, so the next item can be accepted while it waits to be taken.
module particle_splat_distance_field #(
	parameter int GRID_MAX  = 256,
	parameter int REACH_MAX = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [psdf_pkg::IDXW-1:0]      cfg_index,
	input  logic [23:0]                    cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [1:0]                     func,
	input  logic signed [12:0]             cell_x,
	input  logic signed [12:0]             cell_y,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [23:0]             distance_q,
	output logic                           inside_res
);

	localparam int GB = $clog2(GRID_MAX);
	localparam int AW = 2 * GB;
	localparam int CW = psdf_pkg::CW;
	localparam int OW = psdf_pkg::OW;
	localparam int D2W = psdf_pkg::D2W;
	localparam logic [CW-1:0] GRID_MAX_C = CW'(GRID_MAX);
	localparam logic [CW-1:0] REACH_MAX_C = CW'(REACH_MAX);
	localparam logic [OW-1:0] REACH_MAX_O = OW'(REACH_MAX);

	psdf_pkg::state_t state_q, state_d;

	logic [8:0]  grid_size_q;
	logic [6:0]  splat_reach_q;
	logic [13:0] splat_limit_q;
	logic [23:0] cell_size_q;
	logic [22:0] empty_value_q;

	logic                 mem [2**AW];
	logic                 rd_q;
	logic                 mem_we;
	logic                 mem_wd;
	logic [AW-1:0]        mem_addr;
	logic [AW-1:0]        clr_q;

	logic signed [12:0]   x_q, y_q;
	logic signed [OW-1:0] dx_q, dy_q, lim_q;
	logic                 cin_q, inside_q, found_q;
	logic [D2W-1:0]       best_q;
	logic                 scan_s1, vld_s1, last_s1;
	logic [D2W-1:0]       d2_s1;

	logic [37:0]          p_q;
	logic [63:0]          mc_q, acc_q, res_q, bit_q;
	logic [23:0]          msk_q;
	logic [4:0]           cnt_q;

	logic                 out_valid_q, out_inside_q;
	logic signed [23:0]   out_dist_q;

	logic [CW-1:0]        g_use, g_quarter;
	logic signed [CW-1:0] gs, px, py, in_x, in_y;
	logic signed [OW-1:0] ox, oy;
	logic [OW-1:0]        reach_w, rsp_w;
	logic signed [2*OW-1:0] sqx, sqy;
	logic [D2W-1:0]       d2_w;
	logic                 ing_w, in_ok, last_w, hit_w, accept, sq_ge, mul_last;
	logic [63:0]          trial;
	logic [32:0]          dd;
	logic [22:0]          mag;
	logic [37:0]          prod_w;

	assign cfg_ready = 1'b1;

	// grid in use and window reaches
	always_comb begin
		g_use = ({5'b0, grid_size_q} >= GRID_MAX_C) ? GRID_MAX_C : CW'(grid_size_q);
		gs = signed'(g_use);
		g_quarter = g_use >> 2;
		reach_w = (g_quarter > REACH_MAX_C) ? REACH_MAX_O : OW'(g_quarter);
		if (splat_reach_q == 7'd0) begin
			rsp_w = OW'(1);
		end else if ({1'b0, splat_reach_q} > REACH_MAX_O) begin
			rsp_w = REACH_MAX_O;
		end else begin
			rsp_w = {1'b0, splat_reach_q};
		end
	end

	always_comb begin
		in_x = CW'(cell_x);
		in_y = CW'(cell_y);
		in_ok = (in_x >= 0) && (in_x < gs) && (in_y >= 0) && (in_y < gs);
		ox = (state_q == psdf_pkg::ST_QCENTER) ? '0 : dx_q;
		oy = (state_q == psdf_pkg::ST_QCENTER) ? '0 : dy_q;
		px = CW'(x_q) + CW'(ox);
		py = CW'(y_q) + CW'(oy);
		ing_w = (px >= 0) && (px < gs) && (py >= 0) && (py < gs);
		sqx = dx_q * dx_q;
		sqy = dy_q * dy_q;
		d2_w = D2W'($unsigned(sqx) + $unsigned(sqy));
		last_w = (dx_q == lim_q) && (dy_q == lim_q);
		accept = in_valid && in_ready;
		hit_w = scan_s1 && vld_s1 && (rd_q == !inside_q) && (!found_q || d2_s1 < best_q);
		trial = res_q + bit_q;
		sq_ge = acc_q >= trial;
		mul_last = (cnt_q == 5'd23);
		dd = (33'(res_q) + 33'd1) >> 1;
		mag = (found_q && dd < 33'(empty_value_q)) ? 23'(dd) : empty_value_q;
		prod_w = 38'(best_q) * 38'(cell_size_q);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			psdf_pkg::ST_CLEAR: begin
				if (clr_q == '1) state_d = psdf_pkg::ST_IDLE;
			end
			psdf_pkg::ST_IDLE: begin
				if (in_valid) begin
					priority if (func == psdf_pkg::FUNC_ADD && in_ok) begin
						state_d = psdf_pkg::ST_SPLAT;
					end else if (func == psdf_pkg::FUNC_QUERY) begin
						state_d = psdf_pkg::ST_QCENTER;
					end else if (func == psdf_pkg::FUNC_CLEAR) begin
						state_d = psdf_pkg::ST_CLEAR;
					end else begin
						state_d = psdf_pkg::ST_IDLE;
					end
				end
			end
			psdf_pkg::ST_SPLAT: begin
				if (last_w) state_d = psdf_pkg::ST_IDLE;
			end
			psdf_pkg::ST_QCENTER: state_d = psdf_pkg::ST_QWAIT;
			psdf_pkg::ST_QWAIT:   state_d = psdf_pkg::ST_SCAN;
			psdf_pkg::ST_SCAN: begin
				if (last_w) state_d = psdf_pkg::ST_DRAIN;
			end
			psdf_pkg::ST_DRAIN: state_d = psdf_pkg::ST_PROD;
			psdf_pkg::ST_PROD:  state_d = found_q ? psdf_pkg::ST_MUL : psdf_pkg::ST_OUT;
			psdf_pkg::ST_MUL: begin
				if (mul_last) state_d = psdf_pkg::ST_SQRT;
			end
			psdf_pkg::ST_SQRT: begin
				if (bit_q[0]) state_d = psdf_pkg::ST_OUT;
			end
			psdf_pkg::ST_OUT: begin
				if (!out_valid_q || out_ready) state_d = psdf_pkg::ST_IDLE;
			end
			default: state_d = psdf_pkg::ST_IDLE;
		endcase
	end

	// memory port and input handshake
	always_comb begin
		in_ready = 1'b0;
		mem_we = 1'b0;
		mem_wd = 1'b0;
		mem_addr = {py[GB-1:0], px[GB-1:0]};
		unique case (state_q)
			psdf_pkg::ST_CLEAR: begin
				mem_we = 1'b1;
				mem_addr = clr_q;
			end
			psdf_pkg::ST_IDLE: in_ready = 1'b1;
			psdf_pkg::ST_SPLAT: begin
				// the particle cell itself is always marked
				mem_we = ing_w && ((d2_w <= splat_limit_q) || (dx_q == '0 && dy_q == '0));
				mem_wd = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_addr] <= mem_wd;
		rd_q <= mem[mem_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= psdf_pkg::ST_CLEAR;
			clr_q <= '0;
			grid_size_q <= 9'd256;
			splat_reach_q <= 7'd1;
			splat_limit_q <= 14'd1;
			cell_size_q <= 24'd256;
			empty_value_q <= 23'd65536;
			out_valid_q <= 1'b0;
			scan_s1 <= 1'b0;
			found_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					psdf_pkg::REG_GRID_SIZE:   grid_size_q <= cfg_data[8:0];
					psdf_pkg::REG_SPLAT_REACH: splat_reach_q <= cfg_data[6:0];
					psdf_pkg::REG_SPLAT_LIMIT: splat_limit_q <= cfg_data[13:0];
					psdf_pkg::REG_CELL_SIZE:   cell_size_q <= cfg_data;
					psdf_pkg::REG_EMPTY_VALUE: empty_value_q <= cfg_data[22:0];
					default: ;
				endcase
			end
			if (state_q == psdf_pkg::ST_CLEAR) clr_q <= clr_q + AW'(1);
			scan_s1 <= (state_q == psdf_pkg::ST_SCAN);
			if (state_q == psdf_pkg::ST_QWAIT) found_q <= 1'b0;
			else if (hit_w) found_q <= 1'b1;
			if (state_q == psdf_pkg::ST_OUT && (!out_valid_q || out_ready)) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q <= cell_x;
			y_q <= cell_y;
			if (func == psdf_pkg::FUNC_QUERY) begin
				dx_q <= -signed'(reach_w);
				dy_q <= -signed'(reach_w);
				lim_q <= signed'(reach_w);
			end else begin
				dx_q <= -signed'(rsp_w);
				dy_q <= -signed'(rsp_w);
				lim_q <= signed'(rsp_w);
			end
		end
		if (state_q == psdf_pkg::ST_SPLAT || state_q == psdf_pkg::ST_SCAN) begin
			if (dx_q == lim_q) begin
				dx_q <= -lim_q;
				dy_q <= dy_q + OW'(1);
			end else begin
				dx_q <= dx_q + OW'(1);
			end
		end
		if (state_q == psdf_pkg::ST_QCENTER) cin_q <= ing_w;
		if (state_q == psdf_pkg::ST_QWAIT) inside_q <= cin_q & rd_q;
		// scan sample is registered so that it lines up with the registered read data
		vld_s1 <= ing_w;
		d2_s1 <= d2_w;
		last_s1 <= last_w;
		if (hit_w) best_q <= d2_s1;
		if (state_q == psdf_pkg::ST_PROD) begin
			p_q <= prod_w;
			mc_q <= {24'b0, prod_w, 2'b00};
			msk_q <= cell_size_q;
			acc_q <= '0;
			cnt_q <= '0;
		end
		if (state_q == psdf_pkg::ST_MUL) begin
			if (msk_q[0]) acc_q <= acc_q + mc_q;
			mc_q <= mc_q << 1;
			msk_q <= msk_q >> 1;
			cnt_q <= cnt_q + 5'd1;
			res_q <= '0;
			bit_q <= 64'd1 << 62;
		end
		if (state_q == psdf_pkg::ST_SQRT) begin
			if (sq_ge) begin
				acc_q <= acc_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
		if (state_q == psdf_pkg::ST_OUT && (!out_valid_q || out_ready)) begin
			out_dist_q <= inside_q ? -signed'({1'b0, mag}) : signed'({1'b0, mag});
			out_inside_q <= inside_q;
		end
	end

	assign out_valid = out_valid_q;
	assign distance_q = out_dist_q;
	assign inside_res = out_inside_q;

	// the bitmap is never written while a query scans it
	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == psdf_pkg::ST_SCAN || state_q == psdf_pkg::ST_DRAIN) |-> !mem_we)
		else $error("bitmap written during query scan");

	// the root search keeps a single trial bit
	a_sqrt_bit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == psdf_pkg::ST_SQRT) |-> $onehot(bit_q))
		else $error("square root trial bit lost");

	// a result is only offered out of the output step
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == psdf_pkg::ST_OUT))
		else $error("result raised outside output step");

	// the last scan sample is always followed by the drain step
	a_last_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(scan_s1 && last_s1) |-> (state_q == psdf_pkg::ST_DRAIN))
		else $error("scan end out of order");

	// p_q is the distance times cell size product for the serial multiply
	a_prod: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == psdf_pkg::ST_MUL && cnt_q == 5'd0) |-> (mc_q == {24'b0, p_q, 2'b00}))
		else $error("multiplicand mismatch");

endmodule
